@@ rtl/core/lzwd_pkg.sv @@
package lzwd_pkg;

    // Fixed field widths of the token and result streams.
    localparam int BYTE_W      = 8;
    localparam int DIST_W      = 12;
    localparam int LEN_CODE_W  = 5;
    localparam int LEN_W       = 6;   // length code plus minimum length, up to 46
    localparam int TOK_DW_W    = 5;   // effective distance width, up to 15
    localparam int CFG_DW_W    = 4;
    localparam int CFG_LW_W    = 3;
    localparam int CFG_ML_W    = 4;
    localparam int LIMIT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_WIDTH = 2'd0,
        CFG_LEN_WIDTH  = 2'd1,
        CFG_MIN_LEN    = 2'd2,
        CFG_OUT_LIMIT  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        TK_LITERAL,
        TK_SKIP,
        TK_REPEAT,
        TK_MATCH
    } t_tok_kind;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } t_back_state;

    // Decode settings used by the front end.
    typedef struct packed {
        logic [CFG_DW_W-1:0] window_width;
        logic [CFG_LW_W-1:0] len_width;
        logic [CFG_ML_W-1:0] min_len;
    } t_dec_cfg;

    // A classified token as it travels from the front end to the back end.
    typedef struct packed {
        t_tok_kind             kind;
        logic [BYTE_W-1:0]     lit;
        logic [DIST_W-1:0]     distance;
        logic [LEN_W-1:0]      len;
        logic [TOK_DW_W-1:0]   dw;
    } t_token;

endpackage

@@ rtl/core/lzwd_ram.sv @@
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lzwd_front.sv @@
module lzwd_front #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 5
) (
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic                                i_is_literal,
    input  logic [lzwd_pkg::BYTE_W-1:0]         i_literal_byte,
    input  logic [lzwd_pkg::DIST_W-1:0]         i_match_distance,
    input  logic [lzwd_pkg::LEN_CODE_W-1:0]     i_length_code,
    input  lzwd_pkg::t_dec_cfg                  i_cfg,
    input  logic                                i_q_full,
    output logic                                o_push,
    output lzwd_pkg::t_token                    o_tok
);
    import lzwd_pkg::*;

    logic [TOK_DW_W-1:0]   dw_eff;
    logic [CFG_LW_W-1:0]   lw_eff;
    logic [DIST_W-1:0]     dist_mask;
    logic [LEN_CODE_W-1:0] code_mask;
    logic [LEN_W-1:0]      len;

    // Widths above the built-in limits act as the limits.
    assign dw_eff = (TOK_DW_W'(i_cfg.window_width) > TOK_DW_W'(WINDOW_BITS)) ?
                    TOK_DW_W'(WINDOW_BITS) : TOK_DW_W'(i_cfg.window_width);
    assign lw_eff = (i_cfg.len_width > CFG_LW_W'(LENGTH_BITS)) ?
                    CFG_LW_W'(LENGTH_BITS) : i_cfg.len_width;

    assign dist_mask = ~({DIST_W{1'b1}} << dw_eff);
    assign code_mask = ~({LEN_CODE_W{1'b1}} << lw_eff);
    assign len       = LEN_W'(i_length_code & code_mask) + LEN_W'(i_cfg.min_len);

    always_comb begin
        o_tok.lit      = i_literal_byte;
        o_tok.distance = i_match_distance & dist_mask;
        o_tok.len      = len;
        o_tok.dw       = dw_eff;
        if (i_is_literal) begin
            o_tok.kind = TK_LITERAL;
        end else if (len == '0) begin
            o_tok.kind = TK_SKIP;
        end else if (len == LEN_W'(1)) begin
            o_tok.kind = TK_REPEAT;
        end else begin
            o_tok.kind = TK_MATCH;
        end
    end

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

endmodule

@@ rtl/core/lzwd_queue.sv @@
module lzwd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzwd_pkg::t_token i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lzwd_pkg::t_token o_tok
);
    import lzwd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

@@ rtl/core/lzwd_back.sv @@
module lzwd_back #(
    parameter int WINDOW_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lzwd_pkg::t_token                 i_tok,
    input  logic                             i_tok_valid,
    output logic                             o_tok_pop,
    input  logic [lzwd_pkg::LIMIT_W-1:0]     i_limit,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]      o_data,
    output logic                             o_last,
    output logic                             o_bad,
    output logic                             o_fin
);
    import lzwd_pkg::*;

    localparam int AW    = WINDOW_BITS;
    localparam int DEPTH = 1 << WINDOW_BITS;

    t_back_state         r_state, n_state;
    logic [LIMIT_W-1:0]  r_bw, n_bw;
    logic [LIMIT_W-1:0]  r_lim_m1;
    logic [BYTE_W-1:0]   r_prev_lit, n_prev_lit;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0]    r_rd_left, n_rd_left;
    logic [LEN_W-1:0]    r_emit_left, n_emit_left;
    logic                r_rd_vld, n_rd_vld;
    logic                r_byp, n_byp;
    logic [BYTE_W-1:0]   r_byp_data, n_byp_data;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_data, n_out_data;
    logic                r_out_last, n_out_last;
    logic                r_out_bad, n_out_bad;
    logic                r_out_fin, n_out_fin;

    logic                adv, limit_hit, fin_now, dispatch, in_fill, bad, copy_end, issue;
    logic [AW:0]         win_full;
    logic [AW-1:0]       start;
    logic [BYTE_W-1:0]   ram_q, rd_data;
    logic                ram_we, ram_re;
    logic [BYTE_W-1:0]   ram_wdata;

    assign adv       = !r_out_valid || i_ready;
    assign limit_hit = (r_bw >= i_limit);
    assign fin_now   = (r_bw == r_lim_m1);
    assign dispatch  = (r_state == BK_IDLE) && i_tok_valid && adv;

    // While the window is still filling, the distance counts from the first byte.
    assign win_full = {{AW{1'b0}}, 1'b1} << i_tok.dw;
    assign in_fill  = ((r_bw >> i_tok.dw) == '0);
    assign bad      = in_fill && (LIMIT_W'(i_tok.distance) >= r_bw);
    assign start    = in_fill ? AW'(i_tok.distance) :
                      r_bw[AW-1:0] + AW'(i_tok.distance) - win_full[AW-1:0];

    assign rd_data  = r_byp ? r_byp_data : ram_q;
    assign copy_end = r_rd_vld && ((r_emit_left == LEN_W'(1)) || fin_now);
    assign issue    = (r_state == BK_COPY) && adv && !copy_end && (r_rd_left != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (dispatch && !limit_hit && i_tok.kind == TK_MATCH && !bad) begin
                    n_state = BK_COPY;
                end
            end
            BK_COPY: begin
                if (adv && copy_end) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_tok_pop   = dispatch;
        n_bw        = r_bw;
        n_prev_lit  = r_prev_lit;
        n_rd_addr   = r_rd_addr;
        n_rd_left   = r_rd_left;
        n_emit_left = r_emit_left;
        n_rd_vld    = r_rd_vld;
        n_byp       = r_byp;
        n_byp_data  = r_byp_data;
        n_out_valid = adv ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        n_out_fin   = r_out_fin;
        ram_we      = 1'b0;
        ram_wdata   = rd_data;
        ram_re      = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (dispatch && !limit_hit) begin
                    case (i_tok.kind)
                        TK_LITERAL, TK_REPEAT: begin
                            ram_wdata   = (i_tok.kind == TK_LITERAL) ? i_tok.lit : r_prev_lit;
                            ram_we      = 1'b1;
                            n_bw        = r_bw + LIMIT_W'(1);
                            n_prev_lit  = ram_wdata;
                            n_out_valid = 1'b1;
                            n_out_data  = ram_wdata;
                            n_out_last  = 1'b1;
                            n_out_bad   = 1'b0;
                            n_out_fin   = fin_now;
                        end
                        TK_MATCH: begin
                            if (bad) begin
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                                n_out_last  = 1'b1;
                                n_out_bad   = 1'b1;
                                n_out_fin   = 1'b0;
                            end else begin
                                n_rd_addr   = start;
                                n_rd_left   = i_tok.len;
                                n_emit_left = i_tok.len;
                                n_rd_vld    = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_COPY: begin
                if (adv) begin
                    if (r_rd_vld) begin
                        ram_we      = 1'b1;
                        n_bw        = r_bw + LIMIT_W'(1);
                        n_emit_left = r_emit_left - LEN_W'(1);
                        n_out_valid = 1'b1;
                        n_out_data  = rd_data;
                        n_out_last  = copy_end;
                        n_out_bad   = 1'b0;
                        n_out_fin   = fin_now;
                    end
                    n_rd_vld = issue;
                    if (issue) begin
                        // A read of the entry written in this same cycle takes the new byte.
                        ram_re     = 1'b1;
                        n_rd_addr  = r_rd_addr + AW'(1);
                        n_rd_left  = r_rd_left - LEN_W'(1);
                        n_byp      = ram_we && (r_bw[AW-1:0] == r_rd_addr);
                        n_byp_data = rd_data;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_bw        <= '0;
            r_prev_lit  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bw        <= n_bw;
            r_prev_lit  <= n_prev_lit;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_m1    <= i_limit - LIMIT_W'(1);
        r_rd_addr   <= n_rd_addr;
        r_rd_left   <= n_rd_left;
        r_emit_left <= n_emit_left;
        r_byp       <= n_byp;
        r_byp_data  <= n_byp_data;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
        r_out_bad   <= n_out_bad;
        r_out_fin   <= n_out_fin;
    end

    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bw[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_q)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;
    assign o_bad   = r_out_bad;
    assign o_fin   = r_out_fin;

    a_rd_only_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == BK_COPY))
        else $error("window read in flight outside a copy");

    a_copy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_COPY) |-> (r_emit_left != '0))
        else $error("copy running with no bytes left");

    a_fin_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fin) |-> r_out_last)
        else $error("finished byte not marked last of token");

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_data == '0 && !r_out_fin && r_out_last))
        else $error("malformed bad distance result");

endmodule

@@ rtl/core/lzss_window_decompressor_unit.sv @@
// Channel      Dir  Fields (lowest bit first)
// s_axis       in   tdata: literal_byte[7:0], match_distance[19:8], length_code[24:20]
//                   tuser: is_literal
// m_axis       out  tdata: data_byte[7:0]; tlast: last_of_token
//                   tuser: bad_distance[0], finished[1]
// cfg          in   i_cfg_we, i_cfg_index, i_cfg_wdata (write only)
//
// A literal, a length-one repeat, a bad-distance match or a token that gives no
// bytes is finished at dispatch, in the idle state. A match is dispatched first,
// then each of its bytes is read from the window memory and then written and
// sent, since every byte comes from the single read port of the window memory.
// Tokens are classified and queued while the back end works, so the input side
// keeps accepting until the two-entry token queue is full.
// The registered output holds its transaction while m_axis_tready is low, and the
// back end stalls in place. Reset is synchronous and active low; the window
// memory is not cleared, since only bytes already written are ever read.
module lzss_window_decompressor_unit #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Token input.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // literal_byte, match_distance, length_code, zero fill
    input  logic [lzwd_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // is_literal
    input  logic                                  s_axis_tuser,
    // Byte output.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // data_byte
    output logic [lzwd_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                  m_axis_tlast,
    // bad_distance, finished
    output logic [lzwd_pkg::M_TUSER_W-1:0]        m_axis_tuser,
    // Register writes.
    input  logic                                  i_cfg_we,
    input  logic [lzwd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lzwd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import lzwd_pkg::*;

    // Configuration registers, reset to their documented defaults.
    logic [CFG_DW_W-1:0] r_cfg_dw;
    logic [CFG_LW_W-1:0] r_cfg_lw;
    logic [CFG_ML_W-1:0] r_cfg_ml;
    logic [LIMIT_W-1:0]  r_cfg_limit;

    t_dec_cfg dec_cfg;
    t_token   front_tok, q_tok;
    logic     q_full, q_valid, q_pop, push;
    logic     out_bad, out_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dw    <= CFG_DW_W'(12);
            r_cfg_lw    <= CFG_LW_W'(4);
            r_cfg_ml    <= CFG_ML_W'(2);
            r_cfg_limit <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DIST_WIDTH: r_cfg_dw    <= i_cfg_wdata[CFG_DW_W-1:0];
                CFG_LEN_WIDTH:  r_cfg_lw    <= i_cfg_wdata[CFG_LW_W-1:0];
                CFG_MIN_LEN:    r_cfg_ml    <= i_cfg_wdata[CFG_ML_W-1:0];
                CFG_OUT_LIMIT:  r_cfg_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign dec_cfg.window_width = r_cfg_dw;
    assign dec_cfg.len_width    = r_cfg_lw;
    assign dec_cfg.min_len      = r_cfg_ml;

    // Front end: masks the fields to the configured widths, forms the match
    // length and sorts the token into literal, skip, repeat or match.
    lzwd_front #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_tvalid         (s_axis_tvalid),
        .o_tready         (s_axis_tready),
        .i_is_literal     (s_axis_tuser),
        .i_literal_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_match_distance (s_axis_tdata[BYTE_W +: DIST_W]),
        .i_length_code    (s_axis_tdata[BYTE_W + DIST_W +: LEN_CODE_W]),
        .i_cfg            (dec_cfg),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_tok            (front_tok)
    );

    // Short token queue so the two halves stall independently.
    lzwd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    // Back end: owns the byte count, the last literal and the history window,
    // checks the output limit and the distance, and streams the copies.
    lzwd_back #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (q_tok),
        .i_tok_valid (q_valid),
        .o_tok_pop   (q_pop),
        .i_limit     (r_cfg_limit),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_bad       (out_bad),
        .o_fin       (out_fin)
    );

    assign m_axis_tuser = {out_fin, out_bad};

endmodule

@@ verif/lzss_window_decompressor_unit_checker.sv @@
module lzss_window_decompressor_unit_checker #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // literal_byte, match_distance, length_code, zero fill
    input  logic [lzwd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // is_literal
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_byte
    input  logic [lzwd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast,
    // bad_distance, finished
    input  logic [lzwd_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [lzwd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lzwd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic [lzwd_pkg::LIMIT_W-1:0]    o_bytes_written
);
    timeunit 1ns;
    timeprecision 1ps;

    import lzwd_pkg::*;

    localparam int STORE_DEPTH = 1 << WINDOW_BITS;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              bad;
        logic              fin;
    } t_out_byte;

    logic [BYTE_W-1:0]   history [STORE_DEPTH];
    logic [LIMIT_W-1:0]  out_count;
    logic [BYTE_W-1:0]   last_literal;
    logic [CFG_DW_W-1:0] window_width_reg;
    logic [CFG_LW_W-1:0] len_width_reg;
    logic [CFG_ML_W-1:0] min_len_reg;
    logic [LIMIT_W-1:0]  out_limit_reg;
    t_out_byte           byte_queue [$];
    int                  fail_count = 0;

    // Stores one byte in the history, queues it, and tells whether the limit is hit.
    function automatic bit record_byte(input logic [BYTE_W-1:0] b, input bit token_end);
        bit reached;
        history[out_count % STORE_DEPTH] = b;
        out_count = out_count + 1;
        reached = (out_count >= out_limit_reg);
        byte_queue.push_back(t_out_byte'{data: b, last: token_end || reached,
                                         bad: 1'b0, fin: reached});
        return reached;
    endfunction

    function automatic void expand_token(input logic is_lit, input logic [S_TDATA_W-1:0] word);
        int unsigned dw;
        int unsigned lw;
        int unsigned distance;
        int unsigned len;
        int unsigned span;
        int unsigned start;
        if (out_count >= out_limit_reg) begin
            return;
        end
        if (is_lit) begin
            last_literal = word[7:0];
            void'(record_byte(word[7:0], 1'b1));
            return;
        end
        dw       = (window_width_reg > WINDOW_BITS) ? WINDOW_BITS : window_width_reg;
        lw       = (len_width_reg > LENGTH_BITS) ? LENGTH_BITS : len_width_reg;
        distance = word[19:8] & ((1 << dw) - 1);
        len      = (word[24:20] & ((1 << lw) - 1)) + min_len_reg;
        if (len == 0) begin
            return;
        end
        if (len == 1) begin
            void'(record_byte(last_literal, 1'b1));
            return;
        end
        span  = 1 << dw;
        start = (out_count < span) ? distance : (out_count - span + distance);
        if (start >= out_count) begin
            byte_queue.push_back(t_out_byte'{data: '0, last: 1'b1, bad: 1'b1, fin: 1'b0});
            return;
        end
        for (int unsigned i = 0; i < len; i++) begin
            if (record_byte(history[(start + i) % STORE_DEPTH], (i + 1) == len)) begin
                break;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_byte want;
        if (!i_rst_n) begin
            out_count        = '0;
            last_literal     = '0;
            window_width_reg = 4'd12;
            len_width_reg    = 3'd4;
            min_len_reg      = 4'd2;
            out_limit_reg    = '0;
            byte_queue.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected output byte: data=%02h last=%0b user=%02b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end else begin
                    want = byte_queue.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last ||
                        m_axis_tuser[0] !== want.bad || m_axis_tuser[1] !== want.fin) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("byte mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                                     want.data, want.last, want.bad, want.fin,
                                     m_axis_tdata, m_axis_tlast,
                                     m_axis_tuser[0], m_axis_tuser[1]);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_DIST_WIDTH: window_width_reg = i_cfg_wdata[CFG_DW_W-1:0];
                    CFG_LEN_WIDTH:  len_width_reg    = i_cfg_wdata[CFG_LW_W-1:0];
                    CFG_MIN_LEN:    min_len_reg      = i_cfg_wdata[CFG_ML_W-1:0];
                    CFG_OUT_LIMIT:  out_limit_reg    = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expand_token(s_axis_tuser, s_axis_tdata);
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= byte_queue.size();
        o_bytes_written <= out_count;
    end

endmodule

@@ verif/lzss_window_decompressor_unit_test.sv @@
// Stimulus and verdict for the LZSS window decompressor. The checker module beside
// the block watches every transaction, predicts the byte stream and counts failures.
module lzss_window_decompressor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzwd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    // Idle cycles before a register write, so that tokens that make no bytes drain.
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASES         = 8;
    localparam int PHASE_TOKENS   = 18;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_DIST_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    int                    fail_count;
    int                    bytes_pending;
    logic [LIMIT_W-1:0]    bytes_out;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles   = 0;

    // Settings of the random phases; the extremes of each of these three registers appear here.
    int unsigned phase_dw [PHASES] = '{3, 12, 1, 0, 15, 6, 9, 2};
    int unsigned phase_lw [PHASES] = '{4, 5, 2, 7, 3, 0, 6, 1};
    int unsigned phase_ml [PHASES] = '{2, 0, 3, 1, 15, 4, 0, 7};

    always #1ns i_clk = ~i_clk;

    lzss_window_decompressor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lzss_window_decompressor_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (bytes_pending),
        .o_bytes_written (bytes_out)
    );

    // The byte receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // The watchdog ends the run when no transaction and no register write has
    // happened for too long; a leftover expected byte also ends up here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lzss_window_decompressor_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // Offers one token and returns at the edge where its transaction took place.
    // Random gaps lower tvalid first; with no gap, tvalid stays high across tokens.
    task automatic send_token(input logic is_lit, input logic [7:0] lit,
                              input logic [11:0] distance, input logic [4:0] code);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, code, distance, lit};
        s_axis_tuser  <= is_lit;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Most matches point into bytes already written, so that copies dominate over
    // bad-distance results; the rest use a fully random distance.
    task automatic send_random_token(input int unsigned dwe);
        logic [7:0]  lit;
        logic [11:0] distance;
        logic [4:0]  code;
        int unsigned span;
        int unsigned reach;
        lit      = 8'($urandom());
        distance = 12'($urandom());
        code     = 5'($urandom());
        if ($urandom_range(0, 99) < 40) begin
            send_token(1'b1, lit, distance, code);
        end else begin
            span  = 1 << dwe;
            reach = (bytes_out < span) ? bytes_out : span;
            if (reach > 0 && $urandom_range(0, 99) < 85) begin
                distance = 12'(($urandom() & ~(span - 1)) | $urandom_range(0, reach - 1));
            end
            send_token(1'b0, lit, distance, code);
        end
    endtask

    // Waits until every expected byte has come out and the block has gone quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Writes all four registers; the narrow ones get random upper bits that the
    // block has to ignore.
    task automatic apply_settings(input int unsigned dw, input int unsigned lw,
                                  input int unsigned ml, input logic [LIMIT_W-1:0] limit);
        write_reg(CFG_DIST_WIDTH, ($urandom() & ~32'hF) | dw);
        write_reg(CFG_LEN_WIDTH,  ($urandom() & ~32'h7) | lw);
        write_reg(CFG_MIN_LEN,    ($urandom() & ~32'hF) | ml);
        write_reg(CFG_OUT_LIMIT,  limit);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        set_idle(IDLE_NONE);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The output limit is zero after reset, so these tokens make no bytes.
        send_token(1'b1, 8'h11, 12'h000, 5'h00);
        send_token(1'b0, 8'h00, 12'h000, 5'h03);
        settle();
        apply_settings(12, 4, 2, 32'hFFFF_FFFF);

        // A match before anything was written is a bad distance.
        send_token(1'b0, 8'h00, 12'h000, 5'h00);
        send_token(1'b1, 8'h00, 12'h000, 5'h00);
        send_token(1'b1, 8'hFF, 12'h000, 5'h00);
        // A literal with every unused field bit set.
        send_token(1'b1, 8'hA5, 12'hFFF, 5'h1F);
        // Seventeen bytes from the first byte: the copy overlaps its own output.
        send_token(1'b0, 8'h00, 12'h000, 5'h0F);
        // Far past the written bytes; the length code is also masked to four bits.
        send_token(1'b0, 8'hFF, 12'hFFF, 5'h1F);
        // Start at the newest byte, which repeats it twice.
        send_token(1'b0, 8'h00, 12'd19, 5'h00);
        send_token(1'b1, 8'h5A, 12'h000, 5'h00);

        // Length one: the last literal is repeated and the distance is not checked.
        settle();
        apply_settings(0, 0, 1, 32'hFFFF_FFFF);
        send_token(1'b0, 8'h00, 12'hFFF, 5'h1F);

        // Length zero: no bytes at all.
        settle();
        apply_settings(0, 0, 0, 32'hFFFF_FFFF);
        send_token(1'b0, 8'h00, 12'h123, 5'h1F);
        send_token(1'b1, 8'h3C, 12'h000, 5'h00);

        // A one-byte window with the full length code.
        settle();
        apply_settings(0, 5, 0, 32'hFFFF_FFFF);
        send_token(1'b0, 8'h00, 12'hABC, 5'h05);
        send_token(1'b0, 8'h00, 12'h000, 5'h01);
        send_token(1'b0, 8'h00, 12'hFFF, 5'h1F);

        // Register values above their useful range, giving the longest match.
        settle();
        apply_settings(15, 7, 15, 32'hFFFF_FFFF);
        send_token(1'b0, 8'h00, 12'h000, 5'h1F);
        send_token(1'b0, 8'h00, 12'hFFF, 5'h00);
        send_token(1'b1, 8'h81, 12'h000, 5'h00);

        // A copy cut short by the limit; later tokens are ignored.
        settle();
        apply_settings(12, 4, 2, bytes_out + 5);
        send_token(1'b0, 8'h00, 12'h000, 5'h0F);
        send_token(1'b1, 8'h99, 12'h000, 5'h00);
        send_token(1'b0, 8'h00, 12'h000, 5'h02);

        // A literal that lands exactly on the limit.
        settle();
        apply_settings(12, 4, 2, bytes_out + 1);
        send_token(1'b1, 8'h42, 12'h000, 5'h00);

        // A copy whose last byte lands exactly on the limit.
        settle();
        apply_settings(12, 4, 2, bytes_out + 3);
        send_token(1'b0, 8'h00, 12'h001, 5'h01);

        // A limit of zero while bytes have already been written.
        settle();
        apply_settings(12, 4, 2, 32'h0);
        send_token(1'b1, 8'h77, 12'h000, 5'h00);

        // Random phases, each with its own settings and idling pattern. One phase
        // runs into a limit partway through.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            apply_settings(phase_dw[p], phase_lw[p], phase_ml[p],
                           (p == 5) ? bytes_out + 30 : 32'hFFFF_FFFF);
            set_idle(t_idle_mode'(p % 4));
            repeat (PHASE_TOKENS) send_random_token((phase_dw[p] > 12) ? 12 : phase_dw[p]);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && bytes_pending == 0) begin
            $display("lzss_window_decompressor_unit_test: done, clean");
        end else begin
            $display("lzss_window_decompressor_unit_test: done, errors");
        end
        $finish;
    end

endmodule
